// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the scorer RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset
`define HMS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition never holds outside reset
`define HMS_NEVER(label, clk, rst, expr, msg) \
   `HMS_ASSERT(label, clk, rst, !(expr), msg)

`endif

// ===== rtl/hms_pkg.sv =====
package hms_pkg;

   // field widths
   localparam int CoordW = 16;
   localparam int JacW   = 24;
   localparam int HentW  = 20;
   localparam int RowW   = 3 * HentW;
   localparam int ThrW   = 24;
   localparam int SumW   = 34;
   localparam int CntW   = 11;

   // internal datapath widths
   localparam int ProjW    = 37;            // H row dot product, Q.28
   localparam int FracW    = 12;            // projection scale
   localparam int NumW     = ProjW + FracW; // dividend magnitude
   localparam int QuoW     = 37;            // quotient bits developed
   localparam int ErrLimExp = 36;           // error clamp is +/- 2^36
   localparam int ErrW     = 38;            // clamped error, signed
   localparam int ErrSplit = 19;            // low half width of error
   localparam int PartW    = ErrW - ErrSplit + 1;
   localparam int ProdW    = JacW + PartW;
   localparam int AccW     = 64;
   localparam int MagW     = 32;            // pixel error magnitude bits
   localparam int SqShift  = 40;
   localparam int CntBitsW = 6;             // divider step counter
   localparam int QDepth   = 2;
   localparam int QPtrW    = 1;

   localparam longint ErrLimit = 64'sd1 <<< ErrLimExp;
   localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};
   localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};

   typedef enum logic [1:0] {
      CSR_ROW0,
      CSR_ROW1,
      CSR_ROW2,
      CSR_THR
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_ERR,
      ST_MUL,
      ST_SQR,
      ST_FIN
   } back_state_type;

   // one match after the projection front end
   typedef struct packed {
      logic signed [ProjW-1:0]  p0;
      logic signed [ProjW-1:0]  p1;
      logic signed [ProjW-1:0]  p2;
      logic signed [CoordW-1:0] u;
      logic signed [CoordW-1:0] v;
      logic signed [JacW-1:0]   j00;
      logic signed [JacW-1:0]   j01;
      logic signed [JacW-1:0]   j10;
      logic signed [JacW-1:0]   j11;
      logic                     last;
   } match_type;

   // queue handshake between front and back
   typedef struct packed {
      logic push;
      logic pop;
      logic full;
      logic empty;
   } queue_ctl_type;

endpackage

// ===== rtl/hms_front.sv =====
module hms_front import hms_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [CoordW-1:0] req_first_x,
   input  logic signed [CoordW-1:0] req_first_y,
   input  logic signed [CoordW-1:0] req_second_u,
   input  logic signed [CoordW-1:0] req_second_v,
   input  logic signed [JacW-1:0]   req_jac_00,
   input  logic signed [JacW-1:0]   req_jac_01,
   input  logic signed [JacW-1:0]   req_jac_10,
   input  logic signed [JacW-1:0]   req_jac_11,
   input  logic                     req_last_match,
   input  logic [RowW-1:0]          row0,
   input  logic [RowW-1:0]          row1,
   input  logic [RowW-1:0]          row2,
   input  logic                     queue_full,
   output logic                     push,
   output match_type                push_data
);

   logic                     in_valid_ff, in_valid_in;
   logic signed [CoordW-1:0] x_ff, y_ff, u_ff, v_ff;
   logic signed [JacW-1:0]   j00_ff, j01_ff, j10_ff, j11_ff;
   logic                     last_ff;
   logic                     accept;

   // one row of H applied to (x, y, 1), exact in Q.28
   function automatic logic signed [ProjW-1:0] row_dot(
      input logic [RowW-1:0]          row,
      input logic signed [CoordW-1:0] x,
      input logic signed [CoordW-1:0] y
   );
      logic signed [HentW-1:0]        h0, h1, h2;
      logic signed [HentW+CoordW-1:0] t0, t1;
      logic signed [ProjW-1:0]        t2;
      h0 = row[HentW-1:0];
      h1 = row[2*HentW-1:HentW];
      h2 = row[3*HentW-1:2*HentW];
      t0 = h0 * x;
      t1 = h1 * y;
      t2 = ProjW'(h2) <<< FracW;
      return ProjW'(t0) + ProjW'(t1) + t2;
   endfunction

   // hold the item until the queue takes it
   assign push      = in_valid_ff && !queue_full;
   assign req_stall = in_valid_ff && queue_full;
   assign accept    = req_valid && !req_stall;
   assign in_valid_in = accept || (in_valid_ff && !push);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         x_ff    <= req_first_x;
         y_ff    <= req_first_y;
         u_ff    <= req_second_u;
         v_ff    <= req_second_v;
         j00_ff  <= req_jac_00;
         j01_ff  <= req_jac_01;
         j10_ff  <= req_jac_10;
         j11_ff  <= req_jac_11;
         last_ff <= req_last_match;
      end
   end

   // project through H on the way into the queue
   always_comb begin
      push_data.p0   = row_dot(row0, x_ff, y_ff);
      push_data.p1   = row_dot(row1, x_ff, y_ff);
      push_data.p2   = row_dot(row2, x_ff, y_ff);
      push_data.u    = u_ff;
      push_data.v    = v_ff;
      push_data.j00  = j00_ff;
      push_data.j01  = j01_ff;
      push_data.j10  = j10_ff;
      push_data.j11  = j11_ff;
      push_data.last = last_ff;
   end

endmodule

// ===== rtl/hms_queue.sv =====
`include "assert_macros.svh"

module hms_queue import hms_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  match_type push_data,
   input  logic      pop,
   output logic      full,
   output logic      empty,
   output match_type head
);

   match_type              entry_ff [QDepth];
   logic [QPtrW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [QPtrW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [QPtrW:0]         count_ff, count_in;

   assign full  = (count_ff == (QPtrW+1)'(QDepth));
   assign empty = (count_ff == '0);
   assign head  = entry_ff[rd_ptr_ff];

   // advance pointers and fill level
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   `HMS_NEVER(a_push_full, clock, reset, push && full, "push into full match queue")
   `HMS_NEVER(a_pop_empty, clock, reset, pop && empty, "pop from empty match queue")

endmodule

// ===== rtl/hms_div.sv =====
`include "assert_macros.svh"

module hms_div import hms_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [ProjW-1:0] num [2],
   input  logic signed [ProjW-1:0] den,
   output logic                    done,
   output logic signed [ErrW-1:0]  quo [2]
);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CntBitsW-1:0] step_ff, step_in;
   logic [ProjW-1:0]    d_ff, d_in;
   logic [ProjW-1:0]    rem_ff [2];
   logic [ProjW-1:0]    rem_in [2];
   logic [QuoW-1:0]     q_ff [2];
   logic [QuoW-1:0]     q_in [2];
   logic                sat_ff [2];
   logic                sat_in [2];
   logic                neg_ff [2];
   logic                neg_in [2];

   logic [ProjW-1:0]    dmag;
   logic [ProjW-1:0]    nabs [2];
   logic [NumW-1:0]     nmag [2];
   logic [ProjW:0]      shifted [2];
   logic                ge [2];
   logic [QuoW-1:0]     mag [2];
   logic [ErrW-1:0]     magx [2];

   assign dmag = den[ProjW-1] ? ProjW'(-den) : ProjW'(den);

   // load magnitudes on start, then develop one quotient bit per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      d_in    = d_ff;
      for (int i = 0; i < 2; i++) begin
         nabs[i]    = num[i][ProjW-1] ? ProjW'(-num[i]) : ProjW'(num[i]);
         nmag[i]    = {nabs[i], {FracW{1'b0}}};
         shifted[i] = {rem_ff[i], q_ff[i][QuoW-1]};
         ge[i]      = shifted[i] >= {1'b0, d_ff};
         rem_in[i]  = rem_ff[i];
         q_in[i]    = q_ff[i];
         sat_in[i]  = sat_ff[i];
         neg_in[i]  = neg_ff[i];
         if (start) begin
            sat_in[i] = {{QuoW{1'b0}}, nmag[i]} >=
                        {{(NumW+QuoW-ProjW-QuoW){1'b0}}, dmag, {QuoW{1'b0}}};
            neg_in[i] = num[i][ProjW-1] ^ den[ProjW-1];
            rem_in[i] = ProjW'(nmag[i][NumW-1:QuoW]);
            q_in[i]   = nmag[i][QuoW-1:0];
         end else if (busy_ff) begin
            rem_in[i] = ge[i] ? ProjW'(shifted[i] - {1'b0, d_ff}) : shifted[i][ProjW-1:0];
            q_in[i]   = {q_ff[i][QuoW-2:0], ge[i]};
         end
      end
      if (start) begin
         busy_in = 1'b1;
         step_in = CntBitsW'(QuoW - 1);
         d_in    = dmag;
      end else if (busy_ff) begin
         step_in = step_ff - 1'b1;
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      d_ff    <= d_in;
      for (int i = 0; i < 2; i++) begin
         rem_ff[i] <= rem_in[i];
         q_ff[i]   <= q_in[i];
         sat_ff[i] <= sat_in[i];
         neg_ff[i] <= neg_in[i];
      end
   end

   // clamp the truncated quotient to +/- 2^36 and apply the sign
   always_comb begin
      for (int i = 0; i < 2; i++) begin
         if (sat_ff[i] || (q_ff[i] > QuoW'(ErrLimit))) begin
            mag[i] = QuoW'(ErrLimit);
         end else begin
            mag[i] = q_ff[i];
         end
         magx[i] = {1'b0, mag[i]};
         quo[i]  = neg_ff[i] ? $signed(~magx[i] + 1'b1) : $signed(magx[i]);
      end
   end

   assign done = done_ff;

   `HMS_NEVER(a_start_busy, clock, reset, start && busy_ff, "divider restarted while busy")
   `HMS_ASSERT(a_done_after_busy, clock, reset, done_ff |-> $past(busy_ff),
      "divider done without a division")

endmodule

// ===== rtl/hms_back.sv =====
`include "assert_macros.svh"

module hms_back import hms_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic [ThrW-1:0]  threshold,
   input  logic             queue_empty,
   input  match_type        head,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [ThrW-1:0]  rsp_score,
   output logic             rsp_is_inlier,
   output logic             rsp_degenerate,
   output logic [SumW-1:0]  rsp_score_sum,
   output logic [CntW-1:0]  rsp_inlier_count,
   output logic             rsp_last_result
);

   back_state_type          state_ff, state_in;
   match_type               m_ff, m_in;
   logic                    degen_ff, degen_in;
   logic                    big_ff, big_in;
   logic [2:0]              step_ff, step_in;
   logic signed [ErrW-1:0]  e_ff [2];
   logic signed [ErrW-1:0]  e_in [2];
   logic signed [AccW-1:0]  a_ff [2];
   logic signed [AccW-1:0]  a_in [2];
   logic [2*MagW-1:0]       sq_ff [2];
   logic [2*MagW-1:0]       sq_in [2];
   logic [SumW-1:0]         sum_ff, sum_in;
   logic [CntW-1:0]         cnt_ff, cnt_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [ThrW-1:0]         rsp_score_ff, rsp_score_in;
   logic                    rsp_inl_ff, rsp_inl_in;
   logic                    rsp_deg_ff, rsp_deg_in;
   logic [SumW-1:0]         rsp_sum_ff, rsp_sum_in;
   logic [CntW-1:0]         rsp_cnt_ff, rsp_cnt_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic                    div_start, div_done;
   logic signed [ProjW-1:0] div_num [2];
   logic signed [ErrW-1:0]  div_quo [2];
   logic                    out_free;

   logic signed [ErrW:0]    diff [2];
   logic signed [CoordW-1:0] obs [2];
   logic signed [JacW-1:0]  jsel;
   logic signed [ErrW-1:0]  esel;
   logic signed [PartW-1:0] part;
   logic signed [ProdW-1:0] prod;
   logic signed [AccW-1:0]  term;
   logic [AccW-1:0]         amag [2];
   logic [2*MagW:0]         tot;
   logic [2*MagW-SqShift:0] sq;
   logic                    good;
   logic [ThrW-1:0]         score;
   logic [SumW:0]           sum_wide;
   logic [CntW:0]           cnt_wide;

   assign div_num[0] = head.p0;
   assign div_num[1] = head.p1;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   hms_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (head.p2),
      .done  (div_done),
      .quo   (div_quo)
   );

   // error, Jacobian product and squared norm datapath
   always_comb begin
      obs[0] = m_ff.u;
      obs[1] = m_ff.v;
      for (int i = 0; i < 2; i++) begin
         diff[i] = (ErrW+1)'(obs[i]) - (ErrW+1)'(div_quo[i]);
         amag[i] = a_ff[i][AccW-1] ? AccW'(-a_ff[i]) : AccW'(a_ff[i]);
      end
      unique case (step_ff[2:1])
         2'd0: jsel = m_ff.j00;
         2'd1: jsel = m_ff.j01;
         2'd2: jsel = m_ff.j10;
         2'd3: jsel = m_ff.j11;
         default: jsel = m_ff.j00;
      endcase
      esel = e_ff[step_ff[1]];
      if (step_ff[0]) begin
         part = $signed({esel[ErrW-1], esel[ErrW-1:ErrSplit]});
      end else begin
         part = $signed({1'b0, esel[ErrSplit-1:0]});
      end
      prod = jsel * part;
      term = step_ff[0] ? (AccW'(prod) <<< ErrSplit) : AccW'(prod);
      tot  = (2*MagW+1)'(sq_ff[0]) + (2*MagW+1)'(sq_ff[1]);
      sq   = tot[2*MagW:SqShift];
      good = !degen_ff && !big_ff && (sq < (2*MagW-SqShift+1)'(threshold));
      score = good ? sq[ThrW-1:0] : threshold;
      sum_wide = (SumW+1)'(sum_ff) + (SumW+1)'(score);
      cnt_wide = (CntW+1)'(cnt_ff) + (CntW+1)'(good);
   end

   // sequence one match through divide, error, multiply, square, finish (zero denominator: straight to finish)
   always_comb begin
      state_in  = state_ff;
      pop       = 1'b0;
      div_start = 1'b0;
      m_in      = m_ff;
      degen_in  = degen_ff;
      big_in    = big_ff;
      step_in   = step_ff;
      sum_in    = sum_ff;
      cnt_in    = cnt_ff;
      for (int i = 0; i < 2; i++) begin
         e_in[i]  = e_ff[i];
         a_in[i]  = a_ff[i];
         sq_in[i] = sq_ff[i];
      end
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_score_in = rsp_score_ff;
      rsp_inl_in   = rsp_inl_ff;
      rsp_deg_in   = rsp_deg_ff;
      rsp_sum_in   = rsp_sum_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_last_in  = rsp_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!queue_empty) begin
               pop      = 1'b1;
               m_in     = head;
               degen_in = (head.p2 == '0);
               big_in   = 1'b0;
               if (head.p2 == '0) begin
                  state_in = ST_FIN;
               end else begin
                  div_start = 1'b1;
                  state_in  = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_ERR;
            end
         end
         ST_ERR: begin
            for (int i = 0; i < 2; i++) begin
               if (diff[i] > ErrLimit) begin
                  e_in[i] = ErrW'(ErrLimit);
               end else if (diff[i] < -ErrLimit) begin
                  e_in[i] = ErrW'(-ErrLimit);
               end else begin
                  e_in[i] = ErrW'(diff[i]);
               end
               a_in[i] = '0;
            end
            step_in  = '0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            a_in[step_ff[2]] = a_ff[step_ff[2]] + term;
            step_in = step_ff + 1'b1;
            if (step_ff == 3'd7) begin
               state_in = ST_SQR;
            end
         end
         ST_SQR: begin
            big_in = (amag[0][AccW-1:MagW] != '0) || (amag[1][AccW-1:MagW] != '0);
            for (int i = 0; i < 2; i++) begin
               sq_in[i] = amag[i][MagW-1:0] * amag[i][MagW-1:0];
            end
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (degen_ff) begin
               sq_in[0] = '0;
               sq_in[1] = '0;
            end
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_score_in = score;
               rsp_inl_in   = good;
               rsp_deg_in   = degen_ff;
               rsp_sum_in   = sum_wide[SumW] ? SumMax : sum_wide[SumW-1:0];
               rsp_cnt_in   = cnt_wide[CntW] ? CntMax : cnt_wide[CntW-1:0];
               rsp_last_in  = m_ff.last;
               if (m_ff.last) begin
                  sum_in = '0;
                  cnt_in = '0;
               end else begin
                  sum_in = rsp_sum_in;
                  cnt_in = rsp_cnt_in;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      m_ff         <= m_in;
      degen_ff     <= degen_in;
      big_ff       <= big_in;
      step_ff      <= step_in;
      rsp_score_ff <= rsp_score_in;
      rsp_inl_ff   <= rsp_inl_in;
      rsp_deg_ff   <= rsp_deg_in;
      rsp_sum_ff   <= rsp_sum_in;
      rsp_cnt_ff   <= rsp_cnt_in;
      rsp_last_ff  <= rsp_last_in;
      for (int i = 0; i < 2; i++) begin
         e_ff[i]  <= e_in[i];
         a_ff[i]  <= a_in[i];
         sq_ff[i] <= sq_in[i];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_score        = rsp_score_ff;
   assign rsp_is_inlier    = rsp_inl_ff;
   assign rsp_degenerate   = rsp_deg_ff;
   assign rsp_score_sum    = rsp_sum_ff;
   assign rsp_inlier_count = rsp_cnt_ff;
   assign rsp_last_result  = rsp_last_ff;

   `HMS_ASSERT(a_rsp_from_fin, clock, reset,
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FIN), "result without finish step")
   `HMS_NEVER(a_degen_inlier, clock, reset, rsp_valid_ff && rsp_deg_ff && rsp_inl_ff,
      "degenerate match flagged as inlier")

endmodule

// ===== rtl/homography_mlesac_scorer_unit.sv =====
// Scores point matches against a homography held in four registers (three packed Q4.16
// rows and a Q16.8 squared-error limit) and keeps a running score sum and inlier count
// that clear after a match marked last. While the result side is free, the back end
// takes each item through a fetch step, the restoring divider (37 quotient bits, one
// per cycle, both projections at once, then the done flag), a clamp step, eight
// partial products on one shared 24x20 multiplier for the Jacobian, a square step and
// a deliver step. A match with a zero denominator skips the divider and the multiplier.
// The front end projects through H as an item enters and buffers up to three items
// (input register plus a two-entry queue), so the input keeps flowing for a while when
// a result waits on rsp_stall. Registers are written through the csr port, which is
// always ready; write them only when idle.
module homography_mlesac_scorer_unit import hms_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [1:0]               csr_index,
   input  logic [RowW-1:0]          csr_data,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [CoordW-1:0] req_first_x,
   input  logic signed [CoordW-1:0] req_first_y,
   input  logic signed [CoordW-1:0] req_second_u,
   input  logic signed [CoordW-1:0] req_second_v,
   input  logic signed [JacW-1:0]   req_jac_00,
   input  logic signed [JacW-1:0]   req_jac_01,
   input  logic signed [JacW-1:0]   req_jac_10,
   input  logic signed [JacW-1:0]   req_jac_11,
   input  logic                     req_last_match,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [ThrW-1:0]          rsp_score,
   output logic                     rsp_is_inlier,
   output logic                     rsp_degenerate,
   output logic [SumW-1:0]          rsp_score_sum,
   output logic [CntW-1:0]          rsp_inlier_count,
   output logic                     rsp_last_result
);

   logic [RowW-1:0] row0_ff, row0_in;
   logic [RowW-1:0] row1_ff, row1_in;
   logic [RowW-1:0] row2_ff, row2_in;
   logic [ThrW-1:0] thr_ff, thr_in;
   queue_ctl_type   qctl;
   match_type       push_data;
   match_type       head;

   assign csr_ready = 1'b1;

   // write one register per handshake
   always_comb begin
      row0_in = row0_ff;
      row1_in = row1_ff;
      row2_in = row2_ff;
      thr_in  = thr_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_ROW0: row0_in = csr_data;
            CSR_ROW1: row1_in = csr_data;
            CSR_ROW2: row2_in = csr_data;
            CSR_THR:  thr_in  = csr_data[ThrW-1:0];
            default:  thr_in  = thr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row0_ff <= RowW'(64'd1) << (HentW - 4);
         row1_ff <= RowW'(64'd1) << (HentW + HentW - 4);
         row2_ff <= RowW'(64'd1) << (2*HentW + HentW - 4);
         thr_ff  <= ThrW'(4096);
      end else begin
         row0_ff <= row0_in;
         row1_ff <= row1_in;
         row2_ff <= row2_in;
         thr_ff  <= thr_in;
      end
   end

   hms_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_first_x    (req_first_x),
      .req_first_y    (req_first_y),
      .req_second_u   (req_second_u),
      .req_second_v   (req_second_v),
      .req_jac_00     (req_jac_00),
      .req_jac_01     (req_jac_01),
      .req_jac_10     (req_jac_10),
      .req_jac_11     (req_jac_11),
      .req_last_match (req_last_match),
      .row0           (row0_ff),
      .row1           (row1_ff),
      .row2           (row2_ff),
      .queue_full     (qctl.full),
      .push           (qctl.push),
      .push_data      (push_data)
   );

   hms_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (qctl.push),
      .push_data (push_data),
      .pop       (qctl.pop),
      .full      (qctl.full),
      .empty     (qctl.empty),
      .head      (head)
   );

   hms_back u_back (
      .clock            (clock),
      .reset            (reset),
      .threshold        (thr_ff),
      .queue_empty      (qctl.empty),
      .head             (head),
      .pop              (qctl.pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_score        (rsp_score),
      .rsp_is_inlier    (rsp_is_inlier),
      .rsp_degenerate   (rsp_degenerate),
      .rsp_score_sum    (rsp_score_sum),
      .rsp_inlier_count (rsp_inlier_count),
      .rsp_last_result  (rsp_last_result)
   );

endmodule
